// ===== sv/mod_q_butterfly_twiddle_fault_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef MOD_Q_BUTTERFLY_TWIDDLE_FAULT_MACROS_SVH
`define MOD_Q_BUTTERFLY_TWIDDLE_FAULT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MQB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mqbtf_pkg.sv =====
package mqbtf_pkg;

    // q = 2^23 - 2^13 + 1, so 2^23 == 2^13 - 1 (mod q)
    localparam int unsigned Q      = 8380417;
    localparam int unsigned Q_FOLD = 8191;

    localparam int unsigned COEF_W = 23;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned TW_W   = 32;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [1:0] {
        FM_NONE  = 2'd0,
        FM_WRONG = 2'd1,
        FM_VALUE = 2'd2
    } t_fault_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_FAULT_MODE   = 3'd0,
        REG_TARGET_POS   = 3'd1,
        REG_NORMAL_TW    = 3'd2,
        REG_WRONG_TW     = 3'd3,
        REG_FAULT_VALUE  = 3'd4
    } t_reg_idx;

    localparam logic [1:0]        RST_FAULT_MODE  = 2'd0;
    localparam logic [POS_W-1:0]  RST_TARGET_POS  = 6'd17;
    localparam logic [COEF_W-1:0] RST_NORMAL_TW   = 23'd50838;
    localparam logic [COEF_W-1:0] RST_WRONG_TW    = 23'd0;
    localparam logic [TW_W-1:0]   RST_FAULT_VALUE = 32'd0;

    // Side data that rides along the pipe next to the arithmetic.
    typedef struct packed {
        logic [COEF_W-1:0] top;
        logic [TW_W-1:0]   zeta;
        logic              neg;
        logic              faulted;
    } t_side;

endpackage

// ===== sv/mod_q_butterfly_twiddle_fault.sv =====
// Channel   | Direction | Signals                                   | Transfer when
// ----------+-----------+-------------------------------------------+---------------------------
// item in   | in        | i_start, o_busy, i_pair_index,            | i_start && !o_busy
//           |           | i_coef_top, i_coef_bottom                 |
// result    | out       | o_valid, o_sum_coef, o_diff_coef,         | o_valid (one cycle each)
//           |           | o_twiddle_used, o_fault_applied           |
// config    | in        | i_cfg_valid, o_cfg_ready, i_cfg_index,    | i_cfg_valid && o_cfg_ready
//           |           | i_cfg_data                                |
//
// Six register stages; one item per cycle. The result comes from the last stage's registers.
// Stage depth is set by the 23x23 multiplier and the shift-add modular folds around it.
// o_busy stays low: the pipe never stalls, since the receiver cannot hold results off.
// Reset (synchronous, active low) clears the valid bits and loads the register defaults.
// Config must be written only while the pipe is empty; unenforced, o_cfg_ready is always high.
module mod_q_butterfly_twiddle_fault (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item in
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [mqbtf_pkg::POS_W-1:0]         i_pair_index,
    input  logic [mqbtf_pkg::COEF_W-1:0]        i_coef_top,
    input  logic [mqbtf_pkg::COEF_W-1:0]        i_coef_bottom,
    // result
    output logic                                o_valid,
    output logic [mqbtf_pkg::COEF_W-1:0]        o_sum_coef,
    output logic [mqbtf_pkg::COEF_W-1:0]        o_diff_coef,
    output logic signed [mqbtf_pkg::TW_W-1:0]   o_twiddle_used,
    output logic                                o_fault_applied,
    // config write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mqbtf_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [mqbtf_pkg::TW_W-1:0]          i_cfg_data
);

    localparam logic [22:0] Q23 = 23'(mqbtf_pkg::Q);
    localparam logic [23:0] Q24 = 24'(mqbtf_pkg::Q);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0]                       r_fault_mode;
    logic [mqbtf_pkg::POS_W-1:0]      r_target_pos;
    logic [mqbtf_pkg::COEF_W-1:0]     r_normal_tw;
    logic [mqbtf_pkg::COEF_W-1:0]     r_wrong_tw;
    logic [mqbtf_pkg::TW_W-1:0]       r_fault_value;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_mode  <= mqbtf_pkg::RST_FAULT_MODE;
            r_target_pos  <= mqbtf_pkg::RST_TARGET_POS;
            r_normal_tw   <= mqbtf_pkg::RST_NORMAL_TW;
            r_wrong_tw    <= mqbtf_pkg::RST_WRONG_TW;
            r_fault_value <= mqbtf_pkg::RST_FAULT_VALUE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mqbtf_pkg::t_reg_idx'(i_cfg_index))
                mqbtf_pkg::REG_FAULT_MODE:  r_fault_mode  <= i_cfg_data[1:0];
                mqbtf_pkg::REG_TARGET_POS:  r_target_pos  <= i_cfg_data[5:0];
                mqbtf_pkg::REG_NORMAL_TW:   r_normal_tw   <= i_cfg_data[22:0];
                mqbtf_pkg::REG_WRONG_TW:    r_wrong_tw    <= i_cfg_data[22:0];
                mqbtf_pkg::REG_FAULT_VALUE: r_fault_value <= i_cfg_data;
                default: ;   // writes past the list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Valid bits, one per stage
    // ---------------------------------------------------------------
    logic [5:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_start && !o_busy};
        end
    end

    // Side data per stage (stages 1..5)
    mqbtf_pkg::t_side r_side [1:5];

    // ---------------------------------------------------------------
    // Stage 1: twiddle select, sign/magnitude, operand reduction
    // ---------------------------------------------------------------
    logic [31:0] n_zeta;
    logic        n_faulted;
    logic        n_hit;
    logic [31:0] n_mag;
    logic [22:0] n_top;
    logic [22:0] n_bot;

    always_comb begin
        n_hit     = (i_pair_index == r_target_pos);
        n_zeta    = {9'd0, r_normal_tw};
        n_faulted = 1'b0;
        case (mqbtf_pkg::t_fault_mode'(r_fault_mode))
            mqbtf_pkg::FM_WRONG: begin
                if (n_hit) begin
                    n_zeta    = {9'd0, r_wrong_tw};
                    n_faulted = 1'b1;
                end
            end
            mqbtf_pkg::FM_VALUE: begin
                if (n_hit) begin
                    n_zeta    = r_fault_value;
                    n_faulted = 1'b1;
                end
            end
            default: ;   // no fault, unused mode code included
        endcase
        // two's complement magnitude; the most negative value maps to 2^31
        n_mag = n_zeta[31] ? (~n_zeta + 32'd1) : n_zeta;
        n_top = (i_coef_top >= Q23) ? (i_coef_top - Q23) : i_coef_top;
        n_bot = (i_coef_bottom >= Q23) ? (i_coef_bottom - Q23) : i_coef_bottom;
    end

    logic [31:0] r1_mag;
    logic [22:0] r1_bot;

    always_ff @(posedge i_clk) begin
        r1_mag   <= n_mag;
        r1_bot   <= n_bot;
        r_side[1] <= '{top: n_top, zeta: n_zeta, neg: n_zeta[31], faulted: n_faulted};
    end

    // ---------------------------------------------------------------
    // Stage 2: magnitude mod q (one fold, one conditional subtract)
    // ---------------------------------------------------------------
    logic [23:0] n_mag_fold;
    logic [22:0] n_mag_red;

    always_comb begin
        // hi*(2^13-1) + lo, hi <= 256 so the sum stays below 2q
        n_mag_fold = 24'({r1_mag[31:23], 13'd0}) - 24'(r1_mag[31:23]) + 24'(r1_mag[22:0]);
        n_mag_red  = (n_mag_fold >= Q24) ? 23'(n_mag_fold - Q24) : n_mag_fold[22:0];
    end

    logic [22:0] r2_mag;
    logic [22:0] r2_bot;

    always_ff @(posedge i_clk) begin
        r2_mag    <= n_mag_red;
        r2_bot    <= r1_bot;
        r_side[2] <= r_side[1];
    end

    // ---------------------------------------------------------------
    // Stage 3: 23x23 product
    // ---------------------------------------------------------------
    logic [45:0] r3_prod;

    always_ff @(posedge i_clk) begin
        r3_prod   <= 46'(r2_mag) * 46'(r2_bot);
        r_side[3] <= r_side[2];
    end

    // ---------------------------------------------------------------
    // Stage 4: two folds, 46 -> 37 -> 28 bits
    // ---------------------------------------------------------------
    logic [36:0] n_x1;
    logic [27:0] n_x2;

    always_comb begin
        n_x1 = 37'({r3_prod[45:23], 13'd0}) - 37'(r3_prod[45:23]) + 37'(r3_prod[22:0]);
        n_x2 = 28'({n_x1[36:23], 13'd0}) - 28'(n_x1[36:23]) + 28'(n_x1[22:0]);
    end

    logic [27:0] r4_x2;

    always_ff @(posedge i_clk) begin
        r4_x2     <= n_x2;
        r_side[4] <= r_side[3];
    end

    // ---------------------------------------------------------------
    // Stage 5: last fold, final subtract, sign fix -> t
    // ---------------------------------------------------------------
    logic [23:0] n_x3;
    logic [22:0] n_r;
    logic [22:0] n_t;

    always_comb begin
        n_x3 = 24'({r4_x2[27:23], 13'd0}) - 24'(r4_x2[27:23]) + 24'(r4_x2[22:0]);
        n_r  = (n_x3 >= Q24) ? 23'(n_x3 - Q24) : n_x3[22:0];
        // negative twiddle: residue of the negated product
        n_t  = (r_side[4].neg && (n_r != 23'd0)) ? (Q23 - n_r) : n_r;
    end

    logic [22:0] r5_t;

    always_ff @(posedge i_clk) begin
        r5_t      <= n_t;
        r_side[5] <= r_side[4];
    end

    // ---------------------------------------------------------------
    // Stage 6: butterfly add/sub into output registers
    // ---------------------------------------------------------------
    logic [23:0] n_sum_full;
    logic [22:0] n_sum;
    logic [22:0] n_diff;

    always_comb begin
        n_sum_full = 24'(r_side[5].top) + 24'(r5_t);
        n_sum      = (n_sum_full >= Q24) ? 23'(n_sum_full - Q24) : n_sum_full[22:0];
        n_diff     = (r_side[5].top >= r5_t) ? (r_side[5].top - r5_t)
                                             : 23'(24'(r_side[5].top) + Q24 - 24'(r5_t));
    end

    logic [22:0] r_sum;
    logic [22:0] r_diff;
    logic [31:0] r_tw_used;
    logic        r_faulted;

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_diff    <= n_diff;
        r_tw_used <= r_side[5].zeta;
        r_faulted <= r_side[5].faulted;
    end

    assign o_valid         = r_vld[5];
    assign o_sum_coef      = r_sum;
    assign o_diff_coef     = r_diff;
    assign o_twiddle_used  = signed'(r_tw_used);
    assign o_fault_applied = r_faulted;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
`include "mod_q_butterfly_twiddle_fault_macros.svh"

    `MQB_ASSERT_IMP(a_mag_reduced, i_clk, i_rst_n, r_vld[1], r2_mag < Q23)
    `MQB_ASSERT_IMP(a_t_reduced, i_clk, i_rst_n, r_vld[4], r5_t < Q23)
    `MQB_ASSERT_NXT(a_out_reduced, i_clk, i_rst_n, r_vld[4],
                    (o_sum_coef < Q23) && (o_diff_coef < Q23))

endmodule
